### design/masked_byte_pattern_search_core_assert.svh
//==============================================================================
// masked_byte_pattern_search_core_assert.svh
// Assertion macros used by the checker file of the byte pattern search.
//==============================================================================
`ifndef MASKED_BYTE_PATTERN_SEARCH_CORE_ASSERT_SVH
`define MASKED_BYTE_PATTERN_SEARCH_CORE_ASSERT_SVH

// Property checked only while out of reset.
`define MBPS_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("mbps assertion failed");

// Property checked at every edge, reset included.
`define MBPS_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("mbps assertion failed");

`endif

### design/mbps_pkg.sv
//==============================================================================
// mbps_pkg
// Types and constants of the masked byte pattern search.
//==============================================================================
package mbps_pkg;

    localparam int WINDOW_DEPTH = 16;
    localparam int CFG_IDX_W    = 3;
    localparam int ADDR_W       = 64;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PAT_LOW  = 3'd0,
        CFG_PAT_HIGH = 3'd1,
        CFG_CARE     = 3'd2,
        CFG_LENGTH   = 3'd3,
        CFG_BASE     = 3'd4,
        CFG_OFFSET   = 3'd5
    } t_cfg_idx;

    // Per-cell compare setup, derived from the pattern registers.
    typedef struct packed {
        logic       in_use;
        logic       care;
        logic [7:0] pat;
    } t_cell_cfg;

endpackage

### design/mbps_cell.sv
//==============================================================================
// mbps_cell
// One window cell: holds a byte, passes it on, compares it to its pattern byte.
//==============================================================================
module mbps_cell
    import mbps_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_shift,
    input  logic       i_clear,
    input  logic [7:0] i_byte_in,
    input  t_cell_cfg  i_cfg,
    output logic [7:0] o_byte,
    output logic       o_hit
);

    logic [7:0] r_byte;
    logic [7:0] n_byte;

    always_comb begin
        n_byte = r_byte;
        if (i_shift) begin
            n_byte = i_clear ? 8'd0 : i_byte_in;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
    end

    assign o_byte = r_byte;
    // don't-care or unused positions always hit
    assign o_hit  = !i_cfg.in_use || !i_cfg.care || (r_byte == i_cfg.pat);

endmodule

### design/masked_byte_pattern_search_core.sv
//==============================================================================
// masked_byte_pattern_search_core
// Streams bytes through a row of window cells and reports the first place
// where a masked pattern of up to 16 bytes matches, or not found at range end.
//==============================================================================
//  channel  | handshake                 | payload
//  ---------+---------------------------+-------------------------------------
//  in       | i_in_valid / o_in_ready   | i_data_byte, i_last_byte
//  out      | o_out_valid / i_out_ready | o_found, o_match_address
//  cfg      | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
//  One word per cycle sustained while results drain. A word shifts into the
//  cell row at accept; in the compare stage the cell compares are ANDed and
//  the address add is done, landing in the output register.
//  Reset (i_rst_n low, synchronous) clears the control and config registers.
//  A waiting result stalls the compare stage only; one more word is taken
//  while the result register is full, then o_in_ready drops.
//==============================================================================
module masked_byte_pattern_search_core
    import mbps_pkg::*;
#(
    parameter int MAX_PATTERN = 16
)(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // byte stream
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [7:0]           i_data_byte,
    input  logic                 i_last_byte,
    // result
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic                 o_found,
    output logic [ADDR_W-1:0]    o_match_address,
    // register writes
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [63:0]          i_cfg_data
);

    // Cells actually needed: window positions past the usable length are
    // never compared.
    localparam int NCELL = (MAX_PATTERN < WINDOW_DEPTH) ? MAX_PATTERN : WINDOW_DEPTH;
    localparam logic [4:0] CAP = 5'(NCELL);

    // Configuration registers
    logic [63:0]       r_pat_lo, r_pat_hi;
    logic [15:0]       r_care;
    logic [4:0]        r_len;
    logic [ADDR_W-1:0] r_base;
    logic [31:0]       r_off;

    // Search state
    logic              r_restart;  // next word starts a fresh range
    logic [ADDR_W-1:0] r_seen, n_seen;
    logic              r_done, n_done;
    logic              r_s1_valid, n_s1_valid;
    logic              r_s1_last;
    logic              r_out_valid, n_out_valid;
    logic              r_found;
    logic [ADDR_W-1:0] r_addr;

    logic              w_accept;
    logic              w_adv;
    logic              w_eval;
    logic              w_match;
    logic              w_emit;
    logic [4:0]        w_ulen;
    logic              w_enough;
    logic [ADDR_W-1:0] w_bias;
    logic [ADDR_W-1:0] w_addr;
    logic [127:0]      w_pat;
    t_cell_cfg         w_cell_cfg [NCELL];
    logic [7:0]        w_byte     [NCELL];
    logic [NCELL-1:0]  w_hit;

    //--------------------------------------------------------------------------
    // Configuration port, always ready; unknown indexes are dropped.
    //--------------------------------------------------------------------------
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_lo <= '0;
            r_pat_hi <= '0;
            r_care   <= '0;
            r_len    <= '0;
            r_base   <= '0;
            r_off    <= '0;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_PAT_LOW:  r_pat_lo <= i_cfg_data;
                CFG_PAT_HIGH: r_pat_hi <= i_cfg_data;
                CFG_CARE:     r_care   <= i_cfg_data[15:0];
                CFG_LENGTH:   r_len    <= i_cfg_data[4:0];
                CFG_BASE:     r_base   <= i_cfg_data;
                CFG_OFFSET:   r_off    <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    //--------------------------------------------------------------------------
    // Static setup from configuration: usable length, per-cell pattern byte
    // and the address bias base + offset - length.
    // Cell k holds the k-th newest byte; it pairs with pattern byte len-1-k.
    //--------------------------------------------------------------------------
    assign w_ulen = (r_len > CAP) ? 5'd0 : r_len;
    assign w_pat  = {r_pat_hi, r_pat_lo};
    assign w_bias = r_base + {{32{r_off[31]}}, r_off} - {59'd0, w_ulen};

    always_comb begin
        logic [4:0] pidx;
        for (int k = 0; k < NCELL; k++) begin
            pidx = w_ulen - 5'(k) - 5'd1;
            w_cell_cfg[k].in_use = (5'(k) < w_ulen);
            w_cell_cfg[k].care   = r_care[pidx[3:0]];
            w_cell_cfg[k].pat    = w_pat[{pidx[3:0], 3'b000} +: 8];
        end
    end

    //--------------------------------------------------------------------------
    // Handshakes. The compare stage moves when the result register is free
    // or being drained; a new word enters when the compare stage is empty or moves.
    //--------------------------------------------------------------------------
    assign w_adv      = !r_out_valid || i_out_ready;
    assign o_in_ready = !r_s1_valid || w_adv;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_eval     = r_s1_valid && w_adv;

    //--------------------------------------------------------------------------
    // Cell row: cell 0 takes the new word, the rest shift; on a fresh range
    // the older positions load zero.
    //--------------------------------------------------------------------------
    for (genvar k = 0; k < NCELL; k++) begin : g_cell
        if (k == 0) begin : g_head
            mbps_cell u_cell (
                .i_clk     (i_clk),
                .i_shift   (w_accept),
                .i_clear   (1'b0),
                .i_byte_in (i_data_byte),
                .i_cfg     (w_cell_cfg[k]),
                .o_byte    (w_byte[k]),
                .o_hit     (w_hit[k])
            );
        end else begin : g_body
            mbps_cell u_cell (
                .i_clk     (i_clk),
                .i_shift   (w_accept),
                .i_clear   (r_restart),
                .i_byte_in (w_byte[k-1]),
                .i_cfg     (w_cell_cfg[k]),
                .o_byte    (w_byte[k]),
                .o_hit     (w_hit[k])
            );
        end
    end

    //--------------------------------------------------------------------------
    // Compare stage
    //--------------------------------------------------------------------------
    assign w_enough = (|r_seen[ADDR_W-1:5]) || (r_seen[4:0] >= w_ulen);
    assign w_match  = !r_done && (w_ulen != 5'd0) && (r_base != '0) && w_enough && (&w_hit);
    assign w_emit   = w_eval && !r_done && (w_match || r_s1_last);
    assign w_addr   = r_seen + w_bias;

    always_comb begin
        n_seen = r_seen;
        if (w_accept) begin
            n_seen = r_restart ? ADDR_W'(1) : r_seen + ADDR_W'(1);
        end

        n_s1_valid = w_accept ? 1'b1 : (w_eval ? 1'b0 : r_s1_valid);

        n_done = r_done;
        if (w_eval) begin
            n_done = r_s1_last ? 1'b0 : (r_done || w_match);
        end

        n_out_valid = r_out_valid;
        if (w_emit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_restart   <= 1'b1;
            r_done      <= 1'b0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_restart <= i_last_byte;
            end
            r_done      <= n_done;
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_seen <= n_seen;
        if (w_accept) begin
            r_s1_last <= i_last_byte;
        end
        if (w_emit) begin
            r_found <= w_match;
            r_addr  <= w_match ? w_addr : '0;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_found         = r_found;
    assign o_match_address = r_addr;

endmodule

### design/mbps_checker.sv
//==============================================================================
// mbps_checker
// Port-level checks of the byte pattern search, bound to the top level.
//==============================================================================
`include "masked_byte_pattern_search_core_assert.svh"

module mbps_checker
    import mbps_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_in_ready,
    input logic                 o_out_valid,
    input logic                 i_out_ready,
    input logic                 o_found,
    input logic [ADDR_W-1:0]    o_match_address
);

    // no result right after reset
    `MBPS_ASSERT_ALWAYS(a_idle_after_reset, i_clk, !i_rst_n |=> !o_out_valid)

    // not-found words carry a zero address
    `MBPS_ASSERT(a_miss_zero_addr, i_clk, i_rst_n,
        (o_out_valid && !o_found) |-> (o_match_address == '0))

    // empty result register never blocks input
    `MBPS_ASSERT(a_ready_when_empty, i_clk, i_rst_n, !o_out_valid |-> o_in_ready)

    // stalled result holds
    `MBPS_ASSERT(a_out_hold, i_clk, i_rst_n,
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_found)
            && $stable(o_match_address)))

endmodule

bind masked_byte_pattern_search_core mbps_checker u_mbps_checker (.*);
